[hw/rtl/cdte_pkg.sv]
// shared types, constants and lookup functions for the civil date to epoch seconds block
// no dependencies; imported by every module of the block
package cdte_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [13:0] FIRST_YEAR      = 14'd1970;
  localparam logic [12:0] RECIP_100       = 13'd5243;   // ceil(2^19 / 100)
  localparam int unsigned RECIP_SHIFT     = 19;
  localparam logic [13:0] HUNDRED         = 14'd100;
  localparam logic [17:0] CYCLE400_DAYS   = 18'd146097;
  localparam logic [10:0] CYCLE4_DAYS     = 11'd1461;
  localparam logic [23:0] DAYNUM_EPOCH    = 24'd719469; // day count of 1970-01-01
  localparam logic [4:0]  HOURS_PER_DAY   = 5'd24;
  localparam logic [5:0]  SIXTY           = 6'd60;
  localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
  localparam logic [3:0]  MONTH_FEB       = 4'd1;
  localparam logic [3:0]  MONTH_MAR       = 4'd2;
  localparam logic [3:0]  MONTH_LAST      = 4'd11;
  localparam logic [3:0]  MONTHS_TO_MARCH = 4'd10;
  localparam logic [4:0]  FEB_LEAP_LEN    = 5'd29;
  localparam logic [6:0]  YOC_LAST        = 7'd99;

  localparam int unsigned EPOCH_W = 38;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EARLY_YEAR = 2'd1;
  localparam logic [1:0] ST_BAD_DAY    = 2'd2;
  localparam logic [1:0] ST_NEGATIVE   = 2'd3;

  typedef struct packed {
    logic [13:0] full_year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        daylight;
  } req_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch_seconds;
    logic [1:0]         status;
  } rsp_t;

  // classified date, march-based month and split year
  typedef struct packed {
    logic [7:0] cent;
    logic [6:0] yoc;
    logic [3:0] m;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       daylight;
    logic [1:0] status;
  } entry_t;

  function automatic logic [4:0] month_len(logic [3:0] month);
    logic [4:0] len;
    unique case (month)
      4'd0:    len = 5'd31;
      4'd1:    len = 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // days before each month, march first
  function automatic logic [8:0] days_before(logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[hw/rtl/cdte_front.sv]
// front end: range checks, year split into century and year of century, month rotation
// depends on cdte_pkg
module cdte_front import cdte_pkg::*; (
  input  req_t   req,
  output entry_t entry
);

  logic [26:0] recip_prod;
  logic [7:0]  cent_raw;
  logic [13:0] hund;
  logic [6:0]  yoc_raw;
  logic        leap;
  logic        day_bad;
  logic [4:0]  len;

  // year / 100 by reciprocal, exact over the 14-bit range
  assign recip_prod = 27'(req.full_year) * 27'(RECIP_100);
  assign cent_raw   = recip_prod[RECIP_SHIFT +: 8];
  assign hund       = 14'(14'(cent_raw) * HUNDRED);
  assign yoc_raw    = 7'(req.full_year - hund);

  // divisible by 4, and not by 100 unless by 400
  assign leap = (req.full_year[1:0] == 2'b00) && ((yoc_raw != '0) || (cent_raw[1:0] == 2'b00));
  assign len  = month_len(req.month);

  assign day_bad = (req.day_of_month > len) &&
                   !((req.month == MONTH_FEB) && leap && (req.day_of_month <= FEB_LEAP_LEN));

  always_comb begin
    entry.day      = req.day_of_month;
    entry.hour     = req.hour;
    entry.minute   = req.minute;
    entry.second   = req.second;
    entry.daylight = req.daylight;
    entry.cent     = cent_raw;
    entry.yoc      = yoc_raw;
    entry.m        = 4'(req.month - MONTH_MAR);

    // january and february belong to the previous march-based year
    if (req.month < MONTH_MAR) begin
      entry.m = 4'(req.month + MONTHS_TO_MARCH);
      if (yoc_raw == '0) begin
        entry.cent = 8'(cent_raw - 8'd1);
        entry.yoc  = YOC_LAST;
      end else begin
        entry.yoc  = 7'(yoc_raw - 7'd1);
      end
    end

    if (req.full_year < FIRST_YEAR) begin
      entry.status = ST_EARLY_YEAR;
    end else if (req.month > MONTH_LAST || day_bad) begin
      entry.status = ST_BAD_DAY;
    end else begin
      entry.status = ST_OK;
    end
  end

endmodule

[hw/rtl/cdte_queue.sv]
// small register queue between front end and arithmetic back end
// depends on cdte_pkg
module cdte_queue import cdte_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

[hw/rtl/cdte_back.sv]
// back end: six-stage day count and seconds pipeline with output register
// depends on cdte_pkg
module cdte_back import cdte_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   head_valid,
  input  entry_t head,
  output logic   pop,
  output logic   rsp_valid,
  input  logic   rsp_ready,
  output rsp_t   rsp
);

  logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, s6_rdy;

  // stage 1: cycle products and day offset
  logic [25:0] s1_p400;
  logic [17:0] s1_p4;
  logic [8:0]  s1_dayoff;
  logic [4:0]  s1_hour;
  logic [5:0]  s1_minute, s1_second;
  logic        s1_dst;
  logic [1:0]  s1_status;
  // stage 2: days since epoch
  logic signed [23:0] s2_days;
  logic [4:0]  s2_hour;
  logic [5:0]  s2_minute, s2_second;
  logic        s2_dst;
  logic [1:0]  s2_status;
  // stage 3: hours
  logic signed [28:0] s3_hrs;
  logic [5:0]  s3_minute, s3_second;
  logic        s3_dst;
  logic [1:0]  s3_status;
  // stage 4: minutes
  logic signed [34:0] s4_mins;
  logic [5:0]  s4_second;
  logic        s4_dst;
  logic [1:0]  s4_status;
  // stage 5: seconds
  logic signed [40:0] s5_total;
  logic [1:0]  s5_status;

  rsp_t rsp_next;

  assign s6_rdy = !s6_v || rsp_ready;
  assign s5_rdy = !s5_v || s6_rdy;
  assign s4_rdy = !s4_v || s5_rdy;
  assign s3_rdy = !s3_v || s4_rdy;
  assign s2_rdy = !s2_v || s3_rdy;
  assign s1_rdy = !s1_v || s2_rdy;
  assign pop    = head_valid && s1_rdy;

  always_comb begin
    rsp_next.epoch_seconds = '0;
    rsp_next.status        = s5_status;
    if (s5_status == ST_OK) begin
      if (s5_total[40]) begin
        rsp_next.status = ST_NEGATIVE;
      end else if (s5_total[39:EPOCH_W] != '0) begin
        rsp_next.epoch_seconds = EPOCH_MAX;
      end else begin
        rsp_next.epoch_seconds = s5_total[EPOCH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v <= head_valid;
      end
      if (s2_rdy) begin
        s2_v <= s1_v;
      end
      if (s3_rdy) begin
        s3_v <= s2_v;
      end
      if (s4_rdy) begin
        s4_v <= s3_v;
      end
      if (s5_rdy) begin
        s5_v <= s4_v;
      end
      if (s6_rdy) begin
        s6_v <= s5_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_p400   <= 26'(head.cent) * 26'(CYCLE400_DAYS);
      s1_p4     <= 18'(head.yoc) * 18'(CYCLE4_DAYS);
      s1_dayoff <= days_before(head.m) + 9'(head.day);
      s1_hour   <= head.hour;
      s1_minute <= head.minute;
      s1_second <= head.second;
      s1_dst    <= head.daylight;
      s1_status <= head.status;
    end
    if (s2_rdy && s1_v) begin
      s2_days   <= signed'(24'(s1_p400[25:2] + 24'(s1_p4[17:2]) + 24'(s1_dayoff)
                           - DAYNUM_EPOCH));
      s2_hour   <= s1_hour;
      s2_minute <= s1_minute;
      s2_second <= s1_second;
      s2_dst    <= s1_dst;
      s2_status <= s1_status;
    end
    if (s3_rdy && s2_v) begin
      s3_hrs    <= 29'(s2_days) * signed'(29'(HOURS_PER_DAY)) + signed'(29'(s2_hour));
      s3_minute <= s2_minute;
      s3_second <= s2_second;
      s3_dst    <= s2_dst;
      s3_status <= s2_status;
    end
    if (s4_rdy && s3_v) begin
      s4_mins   <= 35'(s3_hrs) * signed'(35'(SIXTY)) + signed'(35'(s3_minute));
      s4_second <= s3_second;
      s4_dst    <= s3_dst;
      s4_status <= s3_status;
    end
    if (s5_rdy && s4_v) begin
      s5_total  <= 41'(s4_mins) * signed'(41'(SIXTY)) + signed'(41'(s4_second))
                   - (s4_dst ? signed'(41'(SECS_PER_HOUR)) : 41'sd0);
      s5_status <= s4_status;
    end
    if (s6_rdy && s5_v) begin
      rsp <= rsp_next;
    end
  end

  assign rsp_valid = s6_v;

endmodule

[hw/rtl/civil_date_to_epoch_seconds.sv]
// top level of the civil date to epoch seconds converter
// depends on cdte_pkg, cdte_front, cdte_queue and cdte_back
//
// usage:
//   req channel (req_valid / req_ready / req) takes one broken-down date and
//   time per item: full year, month 0-11, day, hour, minute, second, daylight
//   rsp channel (rsp_valid / rsp_ready / rsp) returns one item per date:
//   seconds since 1970-01-01 00:00 and a status code (ok, year before 1970,
//   month or day too large, negative result); seconds read zero on any error status
//   path: a date taken on req passes the queue write, five arithmetic stages
//   and the output register before it shows on rsp
//   throughput: one item per cycle while rsp_ready is high; the back end pipeline
//   holds one item per stage; the front end classifies an item in the cycle it arrives
//   stall: when rsp_ready is low the pipeline fills stage by stage, then the
//   queue fills; req_ready drops only when the queue is full
//   reset (rst, synchronous): empties the queue and the pipeline; no result
//   is pending afterwards and req_ready is high the next cycle
module civil_date_to_epoch_seconds import cdte_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  entry_t entry;      // classified date from the front end
  entry_t head;       // oldest queued date
  logic   q_full;
  logic   q_head_valid;
  logic   q_pop;
  logic   push;

  // accept whenever the queue has room, even while a result waits on rsp
  assign req_ready = !q_full;
  assign push      = req_valid && req_ready;

  // range checks and year split happen on the incoming item
  cdte_front u_front (
    .req   (req),
    .entry (entry)
  );

  // decouples classification from the arithmetic so each side stalls alone
  cdte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (head)
  );

  // day count, scaling to seconds, daylight correction and saturation
  cdte_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (head),
    .pop        (q_pop),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule
